// ----- rtl/msvsf_pkg.sv -----
`timescale 1ns / 1ps

package msvsf_pkg;

  // the cell chain covers this many model positions per cycle
  localparam int unsigned LANES  = 8;
  localparam int unsigned LANE_W = 3;

  localparam logic [10:0] MODEL_LENGTH_RST = 11'd1;
  localparam logic [7:0]  SCORE_MAX        = 8'hFF;

  typedef enum logic [2:0] {
    CFG_MODEL_LENGTH  = 3'd0,
    CFG_BIAS          = 3'd1,
    CFG_BASE          = 3'd2,
    CFG_ENTRY_PENALTY = 3'd3,
    CFG_EXIT_PENALTY  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_COST    = 1'b0,
    OP_RESIDUE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_REDUCE,
    ST_UPDATE,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic       cmp_valid;
    logic       row_valid;
    logic       clear;
    logic [7:0] begin_score;
    logic [7:0] bias;
  } cell_ctrl_t;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? SCORE_MAX : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- rtl/msvsf_ram.sv -----
`timescale 1ns / 1ps

module msvsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/msvsf_cell.sv -----
`timescale 1ns / 1ps

module msvsf_cell #(
  parameter int unsigned GROUPS   = 128,
  parameter int unsigned ALPHABET = 32
) (
  input  logic                                  clk_i,
  input  msvsf_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                  en_i,
  input  logic [7:0]                            prev_i,
  input  logic                                  cost_we_i,
  input  logic [$clog2(ALPHABET*GROUPS)-1:0]    cost_waddr_i,
  input  logic [7:0]                            cost_wdata_i,
  input  logic [$clog2(ALPHABET*GROUPS)-1:0]    cost_raddr_i,
  input  logic [$clog2(GROUPS)-1:0]             row_raddr_i,
  input  logic [$clog2(GROUPS)-1:0]             row_waddr_i,
  output logic [7:0]                            old_o,
  output logic [7:0]                            lmax_o
);

  import msvsf_pkg::*;

  logic [7:0] cost_rdata;
  logic [7:0] row_rdata;
  logic [7:0] old_eff;
  logic [7:0] score;
  logic [7:0] row_wdata;
  logic [7:0] lmax_q;
  logic [7:0] lmax_d;

  msvsf_ram #(.WIDTH(8), .DEPTH(ALPHABET * GROUPS)) u_cost_ram (
    .clk_i  (clk_i),
    .we_i   (cost_we_i),
    .waddr_i(cost_waddr_i),
    .wdata_i(cost_wdata_i),
    .raddr_i(cost_raddr_i),
    .rdata_o(cost_rdata)
  );

  msvsf_ram #(.WIDTH(8), .DEPTH(GROUPS)) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.cmp_valid),
    .waddr_i(row_waddr_i),
    .wdata_i(row_wdata),
    .raddr_i(row_raddr_i),
    .rdata_o(row_rdata)
  );

  // groups past the fill count were never written and read as zero
  assign old_eff = ctrl_i.row_valid ? row_rdata : 8'd0;
  assign score   = sat_sub(sat_add(max8(prev_i, ctrl_i.begin_score), ctrl_i.bias), cost_rdata);
  // lanes past the model end write back what they hold
  assign row_wdata = en_i ? score : old_eff;

  always_comb begin
    lmax_d = lmax_q;
    if (ctrl_i.clear) begin
      lmax_d = 8'd0;
    end else if (ctrl_i.cmp_valid && en_i) begin
      lmax_d = max8(lmax_q, score);
    end
  end

  always_ff @(posedge clk_i) begin
    lmax_q <= lmax_d;
  end

  assign old_o  = old_eff;
  assign lmax_o = lmax_q;

endmodule

// ----- rtl/msv_profile_score_filter_core.sv -----
`timescale 1ns / 1ps
// cost word: taken while idle, the next word may follow at once
// residue word: no next word is taken until the sweep, drain, reduce and update states end;
//   the row of 8 cells sweeps the profile one group of 8 positions per cycle;
//   a final residue then passes the emit state, which loads the result register once it is free
// overflowed sequences skip the sweep: residues stay idle, a final one goes straight to emit
// reset clears control, config, score state, fill count; the cost table is undefined until written
module msv_profile_score_filter_core #(
  parameter int unsigned MAX_MODEL = 1024,
  parameter int unsigned ALPHABET  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // residue, position, cost, first_residue, zero fill
  input  logic        s_axis_tuser,   // opcode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // final_score
  output logic        m_axis_tuser    // overflow
);

  import msvsf_pkg::*;

  localparam int unsigned GROUPS = (MAX_MODEL + LANES - 1) / LANES;
  localparam int unsigned GW     = $clog2(GROUPS);
  localparam int unsigned CAW    = $clog2(ALPHABET * GROUPS);
  localparam int unsigned RW     = $clog2(ALPHABET);

  function automatic logic [RW-1:0] wrap_res(input logic [4:0] r);
    logic [6:0] v;
    v = {2'b00, r};
    for (int i = 0; i < 8; i++) begin
      if (v >= 7'(ALPHABET)) begin
        v = v - 7'(ALPHABET);
      end
    end
    return v[RW-1:0];
  endfunction

  // input word fields
  logic [4:0]  in_res;
  logic [10:0] in_pos;
  logic [7:0]  in_cost;
  logic        in_first;
  logic        in_acc;
  logic        in_ready;

  assign in_res   = s_axis_tdata[4:0];
  assign in_pos   = s_axis_tdata[15:5];
  assign in_cost  = s_axis_tdata[23:16];
  assign in_first = s_axis_tdata[24];
  assign in_acc   = s_axis_tvalid & in_ready;

  // configuration
  logic [10:0] model_length_q;
  logic [7:0]  bias_q, base_q, entry_q, exit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_length_q <= MODEL_LENGTH_RST;
      bias_q         <= 8'd0;
      base_q         <= 8'd0;
      entry_q        <= 8'd0;
      exit_q         <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODEL_LENGTH:  model_length_q <= cfg_data_i;
        CFG_BIAS:          bias_q         <= cfg_data_i[7:0];
        CFG_BASE:          base_q         <= cfg_data_i[7:0];
        CFG_ENTRY_PENALTY: entry_q        <= cfg_data_i[7:0];
        CFG_EXIT_PENALTY:  exit_q         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // active length, clamped to 1..MAX_MODEL
  logic [31:0]       ml32, m32, last_k32;
  logic [GW-1:0]     last_g;
  logic [LANE_W-1:0] last_lane;
  logic [GW:0]       used_groups;

  assign ml32 = 32'(model_length_q);
  assign m32  = (ml32 == 32'd0) ? 32'd1 :
                (ml32 > 32'(MAX_MODEL)) ? 32'(MAX_MODEL) : ml32;
  assign last_k32    = m32 - 32'd1;
  assign last_g      = last_k32[LANE_W +: GW];
  assign last_lane   = last_k32[LANE_W-1:0];
  assign used_groups = {1'b0, last_g} + (GW+1)'(1);

  // cost write decode
  logic [31:0]       wk32;
  logic              pos_ok;
  logic [LANE_W-1:0] w_lane;
  logic [GW-1:0]     w_grp;
  logic [RW-1:0]     in_res_w;
  logic [CAW-1:0]    cost_waddr;
  logic              cost_wr;

  assign wk32     = 32'(in_pos) - 32'd1;
  assign pos_ok   = (in_pos != 11'd0) && (32'(in_pos) <= 32'(MAX_MODEL));
  assign w_lane   = wk32[LANE_W-1:0];
  assign w_grp    = wk32[LANE_W +: GW];
  assign in_res_w = wrap_res(in_res);
  assign cost_waddr = CAW'(CAW'(in_res_w) * CAW'(GROUPS) + CAW'(w_grp));
  assign cost_wr  = in_acc && (s_axis_tuser == OP_COST) && pos_ok;

  // sequencer state
  seq_state_e    state_q, state_d;
  logic [GW-1:0] rd_g_q, rd_g_d;
  logic          cmp_v_q, cmp_v_d;
  logic [GW-1:0] cmp_g_q, cmp_g_d;
  logic [7:0]    carry_q, carry_d;
  logic [GW:0]   hw_q, hw_d;
  logic [RW-1:0] res_q, res_d;
  logic          last_q, last_d;
  logic [7:0]    best_j_q, best_j_d;
  logic [7:0]    xb_q, xb_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    xe_q, xe_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_score_q, out_score_d;
  logic          out_ovf_q, out_ovf_d;
  logic          cell_clear;

  logic [7:0]    cell_old  [LANES];
  logic [7:0]    cell_lmax [LANES];
  logic [7:0]    xe_all;
  logic          ovf_eff;
  logic [7:0]    bj_next;

  always_comb begin
    xe_all = 8'd0;
    for (int j = 0; j < LANES; j++) begin
      xe_all = max8(xe_all, cell_lmax[j]);
    end
  end

  assign ovf_eff = in_first ? 1'b0 : ovf_q;
  assign bj_next = max8(best_j_q, sat_sub(xe_q, exit_q));

  always_comb begin
    state_d     = state_q;
    rd_g_d      = rd_g_q;
    cmp_v_d     = 1'b0;
    cmp_g_d     = rd_g_q;
    carry_d     = carry_q;
    hw_d        = hw_q;
    res_d       = res_q;
    last_d      = last_q;
    best_j_d    = best_j_q;
    xb_d        = xb_q;
    ovf_d       = ovf_q;
    xe_d        = xe_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_score_d = out_score_q;
    out_ovf_d   = out_ovf_q;
    in_ready    = 1'b0;
    cell_clear  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc && (s_axis_tuser == OP_RESIDUE)) begin
          if (in_first) begin
            hw_d     = '0;
            best_j_d = 8'd0;
            ovf_d    = 1'b0;
            xb_d     = sat_sub(base_q, entry_q);
          end
          res_d  = in_res_w;
          last_d = s_axis_tlast;
          if (!ovf_eff) begin
            rd_g_d     = '0;
            carry_d    = 8'd0;
            cell_clear = 1'b1;
            state_d    = ST_SWEEP;
          end else if (s_axis_tlast) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SWEEP: begin
        cmp_v_d = 1'b1;
        cmp_g_d = rd_g_q;
        if (cmp_v_q) begin
          carry_d = cell_old[LANES-1];
        end
        if (rd_g_q == last_g) begin
          state_d = ST_DRAIN;
        end else begin
          rd_g_d = rd_g_q + GW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        xe_d = xe_all;
        if (used_groups > hw_q) begin
          hw_d = used_groups;
        end
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sat_add(xe_q, bias_q) == SCORE_MAX) begin
          ovf_d = 1'b1;
        end else begin
          best_j_d = bj_next;
          xb_d     = sat_sub(max8(base_q, bj_next), entry_q);
        end
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_score_d = ovf_q ? 8'd0 : best_j_q;
          out_ovf_d   = ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_g_q      <= '0;
      cmp_v_q     <= 1'b0;
      cmp_g_q     <= '0;
      carry_q     <= 8'd0;
      hw_q        <= '0;
      last_q      <= 1'b0;
      best_j_q    <= 8'd0;
      xb_q        <= 8'd0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_g_q      <= rd_g_d;
      cmp_v_q     <= cmp_v_d;
      cmp_g_q     <= cmp_g_d;
      carry_q     <= carry_d;
      hw_q        <= hw_d;
      last_q      <= last_d;
      best_j_q    <= best_j_d;
      xb_q        <= xb_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    xe_q        <= xe_d;
    out_score_q <= out_score_d;
    out_ovf_q   <= out_ovf_d;
  end

  // cell chain
  cell_ctrl_t     ctrl;
  logic [CAW-1:0] cost_raddr;

  assign ctrl.cmp_valid   = cmp_v_q;
  assign ctrl.row_valid   = ({1'b0, cmp_g_q} < hw_q);
  assign ctrl.clear       = cell_clear;
  assign ctrl.begin_score = xb_q;
  assign ctrl.bias        = bias_q;
  assign cost_raddr = CAW'(CAW'(res_q) * CAW'(GROUPS) + CAW'(rd_g_q));

  for (genvar j = 0; j < LANES; j++) begin : g_cell
    logic       en;
    logic [7:0] prev;

    assign en = (cmp_g_q < last_g) ||
                ((cmp_g_q == last_g) && (LANE_W'(j) <= last_lane));
    // lane 0 takes the last lane's old score from the previous group
    if (j == 0) begin : g_head
      assign prev = carry_q;
    end else begin : g_body
      assign prev = cell_old[j-1];
    end

    msvsf_cell #(.GROUPS(GROUPS), .ALPHABET(ALPHABET)) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .en_i        (en),
      .prev_i      (prev),
      .cost_we_i   (cost_wr && (w_lane == LANE_W'(j))),
      .cost_waddr_i(cost_waddr),
      .cost_wdata_i(in_cost),
      .cost_raddr_i(cost_raddr),
      .row_raddr_i (rd_g_q),
      .row_waddr_i (cmp_g_q),
      .old_o       (cell_old[j]),
      .lmax_o      (cell_lmax[j])
    );
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_score_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

// ----- tb/tb_msv_profile_score_filter_core.sv -----
`timescale 1ns / 1ps

module tb_msv_profile_score_filter_core;
  import msvsf_pkg::*;

  localparam int unsigned MAX_POS = 1024;
  localparam int unsigned CODES   = 32;

  typedef struct {
    op_e        op;
    logic [4:0] res;
    logic [10:0] pos;
    logic [7:0] cost;
    logic       first;
    logic       last;
  } word_t;

  typedef struct {
    logic [7:0] score;
    logic       ovf;
  } score_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [10:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // residue, position, cost, first_residue, zero fill
  logic        s_axis_tuser;   // opcode
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // final_score
  logic        m_axis_tuser;   // overflow

  msv_profile_score_filter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // scoring state mirrored from the block
  logic [7:0]  cost_mem [CODES*MAX_POS];
  logic [7:0]  row_mem  [MAX_POS];
  logic [7:0]  best_j;
  logic [7:0]  begin_sc;
  logic        ovf_seen;
  logic [10:0] len_reg;
  logic [7:0]  bias_reg;
  logic [7:0]  base_reg;
  logic [7:0]  entry_reg;
  logic [7:0]  exit_reg;

  // entries the stimulus has written so far, so no residue reads a blank one
  bit          wr_map [CODES*MAX_POS];

  word_t       pending [$];
  score_t      score_q [$];
  word_t       cur_word;
  score_t      want;
  logic        in_fire;
  int unsigned send_gap;
  int unsigned hold_gap;
  int unsigned mism;
  bit          calm;
  bit          cost_near;

  function automatic logic [7:0] add_clip(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] sub_floor(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : 8'd0;
  endfunction

  function automatic logic [7:0] bigger(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic int unsigned active_len();
    if (len_reg == 11'd0) return 1;
    if (len_reg > MAX_POS) return MAX_POS;
    return 32'(len_reg);
  endfunction

  function automatic void apply_word(word_t w);
    int unsigned m;
    int unsigned row_base;
    logic [7:0]  prev;
    logic [7:0]  old;
    logic [7:0]  s;
    logic [7:0]  xe;
    score_t      r;
    if (w.op == OP_COST) begin
      if (w.pos >= 1 && w.pos <= MAX_POS) cost_mem[w.res * MAX_POS + w.pos - 1] = w.cost;
      return;
    end
    if (w.first) begin
      for (int i = 0; i < MAX_POS; i++) row_mem[i] = 8'd0;
      best_j   = 8'd0;
      ovf_seen = 1'b0;
      begin_sc = sub_floor(base_reg, entry_reg);
    end
    if (!ovf_seen) begin
      m        = active_len();
      row_base = w.res * MAX_POS;
      prev     = 8'd0;
      xe       = 8'd0;
      for (int unsigned k = 0; k < m; k++) begin
        old        = row_mem[k];
        s          = sub_floor(add_clip(bigger(prev, begin_sc), bias_reg), cost_mem[row_base + k]);
        xe         = bigger(xe, s);
        row_mem[k] = s;
        prev       = old;
      end
      if (add_clip(xe, bias_reg) == 8'hFF) begin
        ovf_seen = 1'b1;
      end else begin
        best_j   = bigger(best_j, sub_floor(xe, exit_reg));
        begin_sc = sub_floor(bigger(base_reg, best_j), entry_reg);
      end
    end
    if (w.last) begin
      r.score = ovf_seen ? 8'd0 : best_j;
      r.ovf   = ovf_seen;
      score_q.push_back(r);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_cost();
    int v;
    if (!cost_near) return 8'($urandom_range(0, 255));
    v = int'(bias_reg) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic push_cost(logic [4:0] res, logic [10:0] pos, logic [7:0] cost);
    word_t w;
    w.op    = OP_COST;
    w.res   = res;
    w.pos   = pos;
    w.cost  = cost;
    w.first = 1'($urandom_range(0, 1));
    w.last  = 1'($urandom_range(0, 1));
    pending.push_back(w);
    if (pos >= 1 && pos <= MAX_POS) wr_map[res * MAX_POS + pos - 1] = 1'b1;
  endtask

  task automatic push_res(logic [4:0] res, bit first, bit last);
    word_t       w;
    int unsigned m;
    m = active_len();
    // fill in any cost entry of this row that the sweep would read blank
    for (int unsigned p = 1; p <= m; p++) begin
      if (!wr_map[res * MAX_POS + p - 1]) push_cost(res, 11'(p), pick_cost());
    end
    w.op    = OP_RESIDUE;
    w.res   = res;
    w.pos   = 11'($urandom_range(0, 2047));
    w.cost  = 8'($urandom_range(0, 255));
    w.first = first;
    w.last  = last;
    pending.push_back(w);
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || s_axis_tvalid || score_q.size() != 0) @(posedge clk_i);
    repeat (active_len() / 8 + 16) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [10:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_MODEL_LENGTH:  len_reg   = val;
      CFG_BIAS:          bias_reg  = val[7:0];
      CFG_BASE:          base_reg  = val[7:0];
      CFG_ENTRY_PENALTY: entry_reg = val[7:0];
      CFG_EXIT_PENALTY:  exit_reg  = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(logic [10:0] len, logic [7:0] b, logic [7:0] bs, logic [7:0] en,
                         logic [7:0] ex);
    wait_idle();
    cfg_write(CFG_MODEL_LENGTH, len);
    cfg_write(CFG_BIAS, {3'd0, b});
    cfg_write(CFG_BASE, {3'd0, bs});
    cfg_write(CFG_ENTRY_PENALTY, {3'd0, en});
    cfg_write(CFG_EXIT_PENALTY, {3'd0, ex});
  endtask

  // mostly well-formed sequences, some with stray first/last flags
  task automatic gen_seqs(int unsigned n_res, int unsigned n_codes, logic [4:0] code0);
    int unsigned done_cnt;
    int unsigned seq_len;
    bit          well;
    bit          fst;
    bit          lst;
    logic [4:0]  code;
    done_cnt = 0;
    while (done_cnt < n_res) begin
      seq_len = $urandom_range(1, 8);
      well    = $urandom_range(0, 99) < 85;
      for (int unsigned i = 0; i < seq_len; i++) begin
        code = code0 + 5'($urandom_range(0, n_codes - 1));
        if (well) begin
          fst = (i == 0);
          lst = (i == seq_len - 1);
        end else begin
          fst = $urandom_range(0, 4) == 0;
          lst = $urandom_range(0, 2) == 0;
        end
        if ($urandom_range(0, 9) == 0)
          push_cost(5'($urandom_range(0, 31)), 11'($urandom_range(0, 2047)), pick_cost());
        push_res(code, fst, lst);
        done_cnt++;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        cur_word      = pending.pop_front();
        s_axis_tdata  <= {7'd0, cur_word.first, cur_word.cost, cur_word.pos, cur_word.res};
        s_axis_tuser  <= cur_word.op;
        s_axis_tlast  <= cur_word.last;
        s_axis_tvalid <= 1'b1;
        send_gap      = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_gap > 0) begin
        hold_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold_gap = pick_gap();
      end
    end
  end

  // check results first, then predict from the word taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (score_q.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("unexpected result: score %0d overflow %0b", m_axis_tdata, m_axis_tuser);
        end else begin
          want = score_q.pop_front();
          if (m_axis_tdata !== want.score || m_axis_tuser !== want.ovf) begin
            mism++;
            if (mism <= 10)
              $display("mismatch: expected score %0d overflow %0b, got score %0d overflow %0b",
                       want.score, want.ovf, m_axis_tdata, m_axis_tuser);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) apply_word(cur_word);
    end
  end

  initial begin
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_MODEL_LENGTH;
    cfg_data_i    = 11'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 32'd0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    in_fire       = 1'b0;
    send_gap      = 0;
    hold_gap      = 0;
    mism          = 0;
    calm          = 1'b0;
    cost_near     = 1'b0;
    len_reg       = MODEL_LENGTH_RST;
    bias_reg      = 8'd0;
    base_reg      = 8'd0;
    entry_reg     = 8'd0;
    exit_reg      = 8'd0;
    best_j        = 8'd0;
    begin_sc      = 8'd0;
    ovf_seen      = 1'b0;
    for (int i = 0; i < MAX_POS; i++) row_mem[i] = 8'd0;

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults after reset, ignored cost writes, code extremes
    push_cost(5'd0, 11'd1, 8'd0);
    push_cost(5'd0, 11'd0, 8'd77);
    push_cost(5'd0, 11'd1025, 8'd1);
    push_cost(5'd0, 11'd2047, 8'd255);
    push_cost(5'd31, 11'd1024, 8'd255);
    push_cost(5'd31, 11'd1, 8'd255);
    push_res(5'd0, 1'b1, 1'b1);
    push_res(5'd31, 1'b1, 1'b0);
    push_res(5'd0, 1'b0, 1'b1);

    set_all(11'd2, 8'd20, 8'd10, 8'd3, 8'd2);
    cost_near = 1'b1;
    push_res(5'd3, 1'b1, 1'b0);
    push_res(5'd3, 1'b0, 1'b0);
    push_res(5'd12, 1'b0, 1'b1);

    // full bias saturates at once, later residues are skipped
    set_all(11'd2, 8'd255, 8'd10, 8'd3, 8'd2);
    push_res(5'd3, 1'b1, 1'b0);
    push_res(5'd3, 1'b0, 1'b1);
    push_res(5'd12, 1'b1, 1'b1);
    wait_idle();
    cfg_write(CFG_BIAS, 11'd0);
    push_res(5'd3, 1'b0, 1'b1);
    push_res(5'd3, 1'b1, 1'b1);

    // new base takes effect on the next first flag or the next score update
    wait_idle();
    cfg_write(CFG_BASE, 11'd200);
    cfg_write(CFG_ENTRY_PENALTY, 11'd0);
    push_res(5'd3, 1'b0, 1'b1);
    push_res(5'd3, 1'b1, 1'b1);

    // zero length acts as one position
    set_all(11'd0, 8'd5, 8'd30, 8'd1, 8'd1);
    push_res(5'd20, 1'b1, 1'b0);
    push_res(5'd20, 1'b0, 1'b1);

    // longer rows on a few codes, short rows on every code
    for (int ph = 0; ph < 10; ph++) begin
      calm      = (ph % 4 == 3);
      cost_near = 1'(ph % 2);
      set_all((ph % 3 == 0) ? 11'($urandom_range(9, 20)) : 11'($urandom_range(1, 8)),
              8'($urandom_range(0, 40)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      if (ph % 3 == 0) gen_seqs(24, 4, 5'd8);
      else gen_seqs(24, CODES, 5'd0);
    end

    calm      = 1'b0;
    cost_near = 1'b0;
    set_all(11'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    gen_seqs(16, CODES, 5'd0);
    set_all(11'd5, 8'd255, 8'd255, 8'd255, 8'd255);
    gen_seqs(12, CODES, 5'd0);
    set_all(11'd3, 8'd0, 8'd255, 8'd0, 8'd0);
    gen_seqs(16, CODES, 5'd0);
    cost_near = 1'b1;
    set_all(11'd9, 8'd8, 8'd255, 8'd255, 8'd0);
    gen_seqs(16, CODES, 5'd0);

    // long row on one code, many groups per residue
    set_all(11'd100, 8'd12, 8'd60, 8'd10, 8'd5);
    gen_seqs(10, 1, 5'd15);
    cost_near = 1'b0;
    set_all(11'd0, 8'd30, 8'd100, 8'd20, 8'd40);
    gen_seqs(16, CODES, 5'd0);

    wait_idle();
    if (mism == 0 && score_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
